[sv/accm_pkg.sv]
// Shared types and constants of the accumulator machine execute core.
// Holds the opcode and status codes, the queued instruction record and the
// reset image of the low data memory words. Depends on nothing.
package accm_pkg;

   localparam int AddrWidth = 8;
   localparam int DataWidth = 32;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_AND = 4'd4,
      OP_NOT = 4'd5,
      OP_OR  = 4'd6,
      OP_LD  = 4'd7,
      OP_ST  = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_DIV0   = 2'd1,
      ST_BADOP  = 2'd2,
      ST_HALTED = 2'd3
   } status_type;

   typedef struct packed {
      op_type                 op;
      logic                   bad;
      logic [AddrWidth-1:0]   address;
   } instr_type;

   function automatic logic [DataWidth-1:0] init_word(input logic [1:0] sel);
      logic [DataWidth-1:0] word;
      case (sel)
         2'd0: word = DataWidth'(10);
         2'd1: word = DataWidth'(20);
         2'd2: word = DataWidth'(5);
         2'd3: word = DataWidth'(2);
         default: word = '0;
      endcase
      return word;
   endfunction

endpackage

[sv/accm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the data memory of the accumulator machine. No dependencies.
module accm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/accm_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Used by the back end of the accumulator machine. Depends on accm_pkg.
module accm_div
   import accm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DataWidth-1:0] num,
   input  logic [DataWidth-1:0] den,
   output logic                 done,
   output logic [DataWidth-1:0] quotient
);

   localparam int CntWidth = $clog2(DataWidth);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic [DataWidth-1:0] quo_ff, quo_in;
   logic [DataWidth:0]   rem_ff, rem_in;
   logic [DataWidth-1:0] den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [DataWidth:0]   rem_shift;
   logic [DataWidth:0]   diff;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      rem_shift = {rem_ff[DataWidth-1:0], quo_ff[DataWidth-1]};
      diff      = rem_shift - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num[DataWidth-1] ? (~num + 1'b1) : num;
         den_in  = den[DataWidth-1] ? (~den + 1'b1) : den;
         rem_in  = '0;
         neg_in  = num[DataWidth-1] ^ den[DataWidth-1];
      end else if (busy_ff) begin
         if (!diff[DataWidth]) begin
            rem_in = diff;
            quo_in = {quo_ff[DataWidth-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DataWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(DataWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

[sv/accm_front.sv]
// Front end of the accumulator machine: accepts instruction transactions,
// flags unknown opcodes and queues them for the back end. Depends on accm_pkg.
module accm_front
   import accm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [3:0]           req_mode,
   input  logic [AddrWidth-1:0] req_address,
   input  logic                 hold,
   input  logic                 pop,
   output instr_type            head,
   output logic                 head_valid
);

   instr_type  entry_ff [2];
   instr_type  entry_in;
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;

   assign req_stall = hold || (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   always_comb begin
      entry_in.op      = op_type'(req_mode);
      entry_in.bad     = req_mode > OP_ST;
      entry_in.address = req_address;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = count_ff != 2'd0;

endmodule

[sv/accm_back.sv]
// Back end of the accumulator machine: initializes the data memory after reset,
// executes queued instructions and holds the result register.
// Depends on accm_pkg, accm_ram and accm_div.
module accm_back
   import accm_pkg::*;
#(
   parameter int MEM_WORDS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  instr_type                   head,
   input  logic                        head_valid,
   output logic                        pop,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DataWidth-1:0] rsp_acc_value,
   output logic signed [DataWidth-1:0] rsp_mem_value,
   output logic [1:0]                  rsp_status
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam int CW = $clog2(MEM_WORDS + 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_RESP
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               clr_cnt_ff, clr_cnt_in;
   logic [DataWidth-1:0]        acc_ff, acc_in;
   logic                        halted_ff, halted_in;
   instr_type                   instr_ff, instr_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [DataWidth-1:0]        res_mem_ff, res_mem_in;
   status_type                  res_status_ff, res_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [DataWidth-1:0] rsp_acc_ff, rsp_acc_in;
   logic signed [DataWidth-1:0] rsp_mem_ff, rsp_mem_in;
   status_type                  rsp_status_ff, rsp_status_in;

   logic [AW-1:0]        idx_map [256];
   logic [AW-1:0]        head_idx;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [DataWidth-1:0] ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [DataWidth-1:0] ram_rdata;
   logic                 div_start;
   logic                 div_done;
   logic [DataWidth-1:0] div_quotient;
   logic [DataWidth-1:0] product;

   for (genvar g = 0; g < 256; g++) begin : g_idx_map
      assign idx_map[g] = AW'(g % MEM_WORDS);
   end

   assign head_idx  = idx_map[head.address];
   assign ram_raddr = (state_ff == S_IDLE) ? head_idx : idx_ff;
   assign product   = acc_ff * ram_rdata;

   accm_ram #(
      .WIDTH(DataWidth),
      .DEPTH(MEM_WORDS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   accm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (acc_ff),
      .den     (ram_rdata),
      .done    (div_done),
      .quotient(div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      acc_in        = acc_ff;
      halted_in     = halted_ff;
      instr_in      = instr_ff;
      idx_in        = idx_ff;
      res_mem_in    = res_mem_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_mem_in    = rsp_mem_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = acc_ff;
      div_start     = 1'b0;
      pop           = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff[AW-1:0];
            ram_wdata  = (clr_cnt_ff < CW'(4)) ? init_word(clr_cnt_ff[1:0]) : '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CW'(MEM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               instr_in = head;
               idx_in   = head_idx;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_mem_in    = ram_rdata;
            res_status_in = ST_OK;
            state_in      = S_RESP;
            if (halted_ff) begin
               res_status_in = ST_HALTED;
            end else if (instr_ff.bad) begin
               res_status_in = ST_BADOP;
               halted_in     = 1'b1;
            end else begin
               case (instr_ff.op)
                  OP_ADD: acc_in = acc_ff + ram_rdata;
                  OP_SUB: acc_in = acc_ff - ram_rdata;
                  OP_MUL: acc_in = product;
                  OP_DIV: begin
                     if (ram_rdata == '0) begin
                        res_status_in = ST_DIV0;
                        halted_in     = 1'b1;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  OP_AND: acc_in = acc_ff & ram_rdata;
                  OP_NOT: acc_in = ~acc_ff;
                  OP_OR:  acc_in = acc_ff | ram_rdata;
                  OP_LD:  acc_in = ram_rdata;
                  OP_ST: begin
                     ram_we     = 1'b1;
                     res_mem_in = acc_ff;
                  end
                  default: begin
                     res_status_in = ST_BADOP;
                     halted_in     = 1'b1;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               acc_in   = div_quotient;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_acc_in    = $signed(acc_ff);
               rsp_mem_in    = $signed(res_mem_ff);
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         acc_ff       <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         acc_ff       <= acc_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      instr_ff      <= instr_in;
      idx_ff        <= idx_in;
      res_mem_ff    <= res_mem_in;
      res_status_ff <= res_status_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_mem_ff    <= rsp_mem_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign clearing      = state_ff == S_CLEAR;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_acc_value = rsp_acc_ff;
   assign rsp_mem_value = rsp_mem_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

[sv/accumulator_machine_execute_core.sv]
// Top level of the accumulator machine execute core.
// Joins the front end queue and the back end. Depends on accm_pkg,
// accm_front and accm_back.
//
// Each transaction on the req_ channel is one instruction (req_mode opcode,
// req_address data word). Each produces exactly one transaction on the rsp_
// channel carrying the accumulator, the addressed memory word after the
// instruction and a status code, in instruction order.
// After reset the data memory is initialized by a clearing pass over all
// MEM_WORDS words, during which req_stall stays high.
// The front end holds up to two instructions, so new transactions are taken
// while the back end works or while a result waits on rsp_stall.
// The back end executes one instruction at a time, through S_IDLE, S_EXEC
// and S_RESP; DIV also waits in S_DIV on the one-bit-per-cycle divider.
// An accepted instruction reaches rsp_valid via the queue and these states.
// A result held by rsp_stall keeps its values; the back end waits for the
// result register before it starts the next instruction.
// A divide by zero or an unknown opcode halts the machine; every later
// instruction returns the halted status until reset.
module accumulator_machine_execute_core
   import accm_pkg::*;
#(
   parameter int MEM_WORDS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [3:0]                  req_mode,
   input  logic [AddrWidth-1:0]        req_address,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DataWidth-1:0] rsp_acc_value,
   output logic signed [DataWidth-1:0] rsp_mem_value,
   output logic [1:0]                  rsp_status
);

   instr_type head;
   logic      head_valid;
   logic      pop;
   logic      clearing;

   accm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_address(req_address),
      .hold       (clearing),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   accm_back #(
      .MEM_WORDS(MEM_WORDS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (pop),
      .clearing     (clearing),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_acc_value(rsp_acc_value),
      .rsp_mem_value(rsp_mem_value),
      .rsp_status   (rsp_status)
   );

endmodule

[sv/accm_chk.sv]
// Port-level checker for the accumulator machine execute core, bound to the
// top level. Depends on accm_pkg and accumulator_machine_execute_core.
module accm_chk
   import accm_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [3:0]                  req_mode,
   input logic [AddrWidth-1:0]        req_address,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [DataWidth-1:0] rsp_acc_value,
   input logic signed [DataWidth-1:0] rsp_mem_value,
   input logic [1:0]                  rsp_status
);

   logic [2:0] pending_ff, pending_in;
   logic       halt_seen_ff, halt_seen_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in   = pending_ff + {2'b0, req_take} - {2'b0, rsp_take};
      halt_seen_in = halt_seen_ff
                  || (rsp_take && (rsp_status == ST_DIV0 || rsp_status == ST_BADOP));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         halt_seen_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         halt_seen_ff <= halt_seen_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_acc_value)
         && $stable(rsp_mem_value) && $stable(rsp_status))
      else $error("Stalled response transaction changed.");

   a_init_stall: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("Request accepted during memory initialization.");

   a_rsp_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid |-> pending_ff != 3'd0) and (pending_ff <= 3'd4))
      else $error("Response transaction count does not match requests.");

   a_div0_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIV0 |-> rsp_mem_value == '0)
      else $error("Divide by zero reported with a nonzero divisor.");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halt_seen_ff |-> rsp_status == ST_HALTED)
      else $error("Machine executed an instruction after halting.");

endmodule

bind accumulator_machine_execute_core accm_chk u_accm_chk (.*);
